/* src/indexed_shift_stack_defines.svh */
// ----------------------------------------------------------------------------
// indexed_shift_stack_defines
// Assertion macros shared by the indexed shift stack modules.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_STACK_DEFINES_SVH
`define INDEXED_SHIFT_STACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iss_pkg.sv */
// ----------------------------------------------------------------------------
// iss_pkg
// Types and codes shared by the indexed shift stack controller and datapath.
// ----------------------------------------------------------------------------
package iss_pkg;

    // Field widths of the request and result.
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd4;

    // Index register update selects.
    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_POS  = 3'd1;
    localparam logic [2:0] IDX_ZERO = 3'd2;
    localparam logic [2:0] IDX_CNT  = 3'd3;
    localparam logic [2:0] IDX_INC  = 3'd4;
    localparam logic [2:0] IDX_DEC  = 3'd5;

    // Memory read address selects.
    localparam logic [2:0] RD_IDX    = 3'd0;
    localparam logic [2:0] RD_IDX_P1 = 3'd1;
    localparam logic [2:0] RD_IDX_M1 = 3'd2;
    localparam logic [2:0] RD_CNT_M1 = 3'd3;
    localparam logic [2:0] RD_POS    = 3'd4;

    // Memory write address selects.
    localparam logic [1:0] WR_IDX = 2'd0;
    localparam logic [1:0] WR_CNT = 2'd1;
    localparam logic [1:0] WR_POS = 2'd2;

    // One request.
    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } req_t;

    // One result.
    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       entry_count;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_req;
        logic [2:0]          idx_sel;
        logic                rd_en;
        logic [2:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic                wr_from_rd;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                cap_data;
        logic                done;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                full;
        logic                pos_ge_cnt;
        logic                pos_gt_cnt;
        logic                match;
        logic                shd_last;
        logic                shu_done;
        logic                scan_end;
    } stat_t;

endpackage

/* src/iss_ctrl.sv */
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer for the indexed shift stack: decodes each request and steps the
// datapath through reads, entry moves and the final result.
// ----------------------------------------------------------------------------
`include "indexed_shift_stack_defines.svh"

module iss_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  iss_pkg::stat_t stat,
    output iss_pkg::cmd_t  cmd
);

    // State codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_POP_WAIT = 4'd2;
    localparam logic [3:0] S_RD_WAIT  = 4'd3;
    localparam logic [3:0] S_DEL_WAIT = 4'd4;
    localparam logic [3:0] S_SHD_CHK  = 4'd5;
    localparam logic [3:0] S_SHD_WR   = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_CMP = 4'd8;
    localparam logic [3:0] S_SHU_CHK  = 4'd9;
    localparam logic [3:0] S_SHU_WR   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = iss_pkg::STATUS_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.action)
                    iss_pkg::ACT_PUSH:
                    begin
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                        if (stat.full)
                        begin
                            cmd.status = iss_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = iss_pkg::WR_CNT;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    iss_pkg::ACT_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = iss_pkg::RD_CNT_M1;
                            state_next = S_POP_WAIT;
                        end
                    end
                    iss_pkg::ACT_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_EMPTY;
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_ge_cnt)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = iss_pkg::RD_POS;
                            cmd.idx_sel = iss_pkg::IDX_POS;
                            state_next  = S_DEL_WAIT;
                        end
                    end
                    iss_pkg::ACT_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_sel = iss_pkg::IDX_ZERO;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    iss_pkg::ACT_READ:
                    begin
                        if (stat.empty)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_EMPTY;
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_ge_cnt)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = iss_pkg::RD_POS;
                            state_next = S_RD_WAIT;
                        end
                    end
                    iss_pkg::ACT_WRITE:
                    begin
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.status = iss_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = iss_pkg::WR_POS;
                        end
                    end
                    iss_pkg::ACT_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_FULL;
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_gt_cnt)
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = iss_pkg::STATUS_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_sel = iss_pkg::IDX_CNT;
                            state_next  = S_SHU_CHK;
                        end
                    end
                    default:
                    begin
                        // The unused action code has no effect.
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.cap_data = 1'b1;
                cmd.cnt_dec  = 1'b1;
                cmd.done     = 1'b1;
                state_next   = S_IDLE;
            end
            S_RD_WAIT:
            begin
                cmd.cap_data = 1'b1;
                cmd.done     = 1'b1;
                state_next   = S_IDLE;
            end
            S_DEL_WAIT:
            begin
                cmd.cap_data = 1'b1;
                state_next   = S_SHD_CHK;
            end
            S_SHD_CHK:
            begin
                // Close the gap one entry at a time, working upwards.
                if (stat.shd_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.done    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iss_pkg::RD_IDX_P1;
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = iss_pkg::WR_IDX;
                cmd.wr_from_rd = 1'b1;
                cmd.idx_sel    = iss_pkg::IDX_INC;
                state_next     = S_SHD_CHK;
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.done   = 1'b1;
                    cmd.status = iss_pkg::STATUS_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iss_pkg::RD_IDX;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_SHD_CHK;
                end
                else
                begin
                    cmd.idx_sel = iss_pkg::IDX_INC;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHU_CHK:
            begin
                // Open a gap one entry at a time, working downwards.
                if (stat.shu_done)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = iss_pkg::WR_POS;
                    cmd.cnt_inc = 1'b1;
                    cmd.done    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iss_pkg::RD_IDX_M1;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = iss_pkg::WR_IDX;
                cmd.wr_from_rd = 1'b1;
                cmd.idx_sel    = iss_pkg::IDX_DEC;
                state_next     = S_SHU_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks on the sequencing.
    `ISS_ASSERT_IMPL(a_scan_only_remove, (state_reg == S_SCAN_RD) || (state_reg == S_SCAN_CMP), stat.action == iss_pkg::ACT_REMOVE, "scan running for an action other than remove")
    `ISS_ASSERT_IMPL(a_done_to_idle, cmd.done, state_next == S_IDLE, "result issued without returning to idle")
    `ISS_ASSERT_IMPL(a_single_port_use, cmd.wr_en, !cmd.rd_en, "memory read and write issued in one cycle")

endmodule

/* src/iss_datapath.sv */
// ----------------------------------------------------------------------------
// iss_datapath
// Entry memory, fill count, working index and result register of the
// indexed shift stack.
// ----------------------------------------------------------------------------
`include "indexed_shift_stack_defines.svh"

module iss_datapath
#(
    parameter int DEPTH = 128
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  iss_pkg::req_t  req,
    input  iss_pkg::cmd_t  cmd,
    output iss_pkg::stat_t stat,
    output logic           done,
    output iss_pkg::res_t  res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > iss_pkg::COUNT_W) ? CW : iss_pkg::COUNT_W;

    logic signed [iss_pkg::WORD_W-1:0] mem [DEPTH];
    logic signed [iss_pkg::WORD_W-1:0] rd_data_reg;
    logic signed [iss_pkg::WORD_W-1:0] data_reg;
    logic signed [iss_pkg::WORD_W-1:0] wr_data;
    iss_pkg::req_t                     req_reg;
    logic [CW-1:0]                     cnt_reg;
    logic [CW-1:0]                     cnt_next;
    logic [CW-1:0]                     idx_reg;
    logic [CW-1:0]                     idx_next;
    logic [CW-1:0]                     idx_p1;
    logic [CW-1:0]                     idx_m1;
    logic [CW-1:0]                     cnt_m1;
    logic [XW-1:0]                     pos_x;
    logic [XW-1:0]                     cnt_x;
    logic [XW-1:0]                     idx_x;
    logic [XW-1:0]                     cnt_next_x;
    logic [AW-1:0]                     rd_addr;
    logic [AW-1:0]                     wr_addr;
    logic                              done_reg;
    iss_pkg::res_t                     res_reg;

    // Widened copies for the range comparisons.
    assign pos_x      = XW'(req_reg.position);
    assign cnt_x      = XW'(cnt_reg);
    assign idx_x      = XW'(idx_reg);
    assign cnt_next_x = XW'(cnt_next);
    assign idx_p1     = idx_reg + CW'(1);
    assign idx_m1     = idx_reg - CW'(1);
    assign cnt_m1     = cnt_reg - CW'(1);

    // Status back to the controller.
    always_comb
    begin
        stat.action     = req_reg.action;
        stat.empty      = (cnt_reg == '0);
        stat.full       = (cnt_reg == CW'(DEPTH));
        stat.pos_ge_cnt = (pos_x >= cnt_x);
        stat.pos_gt_cnt = (pos_x > cnt_x);
        stat.match      = (rd_data_reg == req_reg.value);
        stat.shd_last   = (XW'(idx_p1) >= cnt_x);
        stat.shu_done   = (idx_x <= pos_x);
        stat.scan_end   = (idx_reg >= cnt_reg);
    end

    // Memory address and write data selection.
    always_comb
    begin
        case (cmd.rd_sel)
            iss_pkg::RD_IDX:    rd_addr = idx_reg[AW-1:0];
            iss_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            iss_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            iss_pkg::RD_CNT_M1: rd_addr = cnt_m1[AW-1:0];
            iss_pkg::RD_POS:    rd_addr = pos_x[AW-1:0];
            default:            rd_addr = idx_reg[AW-1:0];
        endcase
        case (cmd.wr_sel)
            iss_pkg::WR_IDX: wr_addr = idx_reg[AW-1:0];
            iss_pkg::WR_CNT: wr_addr = cnt_reg[AW-1:0];
            iss_pkg::WR_POS: wr_addr = pos_x[AW-1:0];
            default:         wr_addr = idx_reg[AW-1:0];
        endcase
        wr_data = cmd.wr_from_rd ? rd_data_reg : req_reg.value;
    end

    // Entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next index and fill count.
    always_comb
    begin
        case (cmd.idx_sel)
            iss_pkg::IDX_HOLD: idx_next = idx_reg;
            iss_pkg::IDX_POS:  idx_next = CW'(pos_x);
            iss_pkg::IDX_ZERO: idx_next = '0;
            iss_pkg::IDX_CNT:  idx_next = cnt_reg;
            iss_pkg::IDX_INC:  idx_next = idx_p1;
            iss_pkg::IDX_DEC:  idx_next = idx_m1;
            default:           idx_next = idx_reg;
        endcase
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_m1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Fill count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.done;
        end
    end

    // Request copy, working index, captured word and result payload.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_req)
        begin
            req_reg  <= req;
            data_reg <= '0;
        end
        else if (cmd.cap_data)
        begin
            data_reg <= rd_data_reg;
        end
        if (cmd.done)
        begin
            res_reg.data        <= cmd.cap_data ? rd_data_reg : data_reg;
            res_reg.status      <= cmd.status;
            res_reg.entry_count <= cnt_next_x[iss_pkg::COUNT_W-1:0];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    // Checks on the fill count.
    `ISS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CW'(DEPTH), "fill count beyond depth")
    `ISS_ASSERT_NEXT(a_cnt_step, cmd.cnt_inc, cnt_reg == $past(cnt_reg) + CW'(1), "fill count did not grow by one")

endmodule

/* src/indexed_shift_stack.sv */
// ----------------------------------------------------------------------------
// indexed_shift_stack
// Bounded stack of signed words that also serves as a list, with push, pop,
// indexed delete, remove by value, indexed read and write, and indexed insert.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Payload  Notes
//  request   start / busy     req      taken when start is high and busy low
//  result    done (strobe)    res      valid for the one cycle done is high
//
// One request is handled at a time. The result strobe is registered from the
// controller's done command and rises in the same cycle that busy falls. Delete,
// insert and remove by value move or scan entries one at a time: a moved entry
// is read and then written, a scanned entry read and then compared. Reset clears
// the count, strobe and controller only.
//
`include "indexed_shift_stack_defines.svh"

module indexed_shift_stack
#(
    parameter int DEPTH = 128
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  iss_pkg::req_t req,
    output logic          done,
    output iss_pkg::res_t res
);

    iss_pkg::cmd_t  cmd;
    iss_pkg::stat_t stat;

    // Controller.
    iss_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath with the entry memory.
    iss_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .res   (res)
    );

    // A request yields a single one-cycle result.
    `ISS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

endmodule

/* dv/indexed_shift_stack_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_shift_stack_checker
// Watches the request and result channels of the indexed shift stack. It
// keeps its own copy of the stored words and the fill level, and works out the
// result of every accepted request. It then compares each result strobe with
// the oldest result still due.
// ----------------------------------------------------------------------------
module indexed_shift_stack_checker
#(
    parameter int DEPTH = 128
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  iss_pkg::req_t                  req,
    input  logic                           done,
    input  iss_pkg::res_t                  res,
    output int                             fail_count,
    output int                             pending,
    output logic [iss_pkg::COUNT_W-1:0]    fill_level
);

    import iss_pkg::*;

    // Mirror of the stored words and of the number held.
    logic [WORD_W-1:0] stack_words [DEPTH];
    int unsigned       held = 0;
    int                failures = 0;

    // Results owed by the block, oldest first.
    res_t              due_results [$];

    assign fail_count = failures;

    // Take out the word at idx; the words above it move down by one.
    function automatic void close_gap(int unsigned idx);
        for (int unsigned i = idx; i + 1 < held; i++)
            stack_words[i] = stack_words[i + 1];
        held--;
    endfunction

    // Apply one request to the mirror and return the result it must produce.
    function automatic res_t predict_result(req_t r);
        res_t        outcome;
        int unsigned pos;
        int unsigned i;
        bit          found;

        outcome.data   = '0;
        outcome.status = STATUS_OK;
        pos            = r.position;
        found          = 1'b0;
        case (r.action)
            ACT_PUSH:
            begin
                if (held >= DEPTH)
                    outcome.status = STATUS_FULL;
                else
                begin
                    stack_words[held] = r.value;
                    held++;
                end
            end
            ACT_POP:
            begin
                if (held == 0)
                    outcome.status = STATUS_EMPTY;
                else
                begin
                    held--;
                    outcome.data = stack_words[held];
                end
            end
            ACT_DELETE:
            begin
                if (held == 0)
                    outcome.status = STATUS_EMPTY;
                else if (pos >= held)
                    outcome.status = STATUS_RANGE;
                else
                begin
                    outcome.data = stack_words[pos];
                    close_gap(pos);
                end
            end
            ACT_REMOVE:
            begin
                if (held == 0)
                    outcome.status = STATUS_EMPTY;
                else
                begin
                    // The first equal word from the bottom is the one removed.
                    outcome.status = STATUS_NOTFOUND;
                    i = 0;
                    while (!found && i < held)
                    begin
                        if (stack_words[i] == r.value)
                        begin
                            close_gap(i);
                            outcome.status = STATUS_OK;
                            found = 1'b1;
                        end
                        i++;
                    end
                end
            end
            ACT_READ:
            begin
                if (held == 0)
                    outcome.status = STATUS_EMPTY;
                else if (pos >= held)
                    outcome.status = STATUS_RANGE;
                else
                    outcome.data = stack_words[pos];
            end
            ACT_WRITE:
            begin
                // An empty store reports a bad position rather than empty.
                if (pos >= held)
                    outcome.status = STATUS_RANGE;
                else
                    stack_words[pos] = r.value;
            end
            ACT_INSERT:
            begin
                // A position equal to the fill level appends at the top.
                if (held >= DEPTH)
                    outcome.status = STATUS_FULL;
                else if (pos > held)
                    outcome.status = STATUS_RANGE;
                else
                begin
                    for (i = held; i > pos; i--)
                        stack_words[i] = stack_words[i - 1];
                    stack_words[pos] = r.value;
                    held++;
                end
            end
            default:
            begin
                // The spare action code leaves everything as it is.
            end
        endcase
        outcome.entry_count = COUNT_W'(held);
        return outcome;
    endfunction

    // Compare results, then record the request taken at this edge.
    always @(posedge clk)
    begin
        res_t want;

        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with none due: data %0d status %0d count %0d",
                             $time, res.data, res.status, res.entry_count);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res.data !== want.data || res.status !== want.status ||
                        res.entry_count !== want.entry_count)
                    begin
                        failures++;
                        $display("%0t: mismatch: expected data %0d status %0d count %0d,",
                                 $time, want.data, want.status, want.entry_count,
                                 " got data %0d status %0d count %0d",
                                 res.data, res.status, res.entry_count);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                due_results.push_back(predict_result(req));
            pending    <= due_results.size();
            fill_level <= COUNT_W'(held);
        end
        else
        begin
            pending    <= 0;
            fill_level <= '0;
        end
    end

endmodule

/* dv/indexed_shift_stack_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_shift_stack_test
// Drives requests into the indexed shift stack: first a directed run over the
// empty store, the field extremes and every action, then random requests that
// fill the store to full and drain it again. This happens over phases with
// and without gaps between requests. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module indexed_shift_stack_test;

    import iss_pkg::*;

    localparam int                  DEPTH           = 128;
    localparam int                  RANDOM_REQUESTS = 950;
    localparam int                  SETTLE_CYCLES   = 20;
    localparam logic [ACTION_W-1:0] ACT_UNUSED      = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    req_t               req;
    res_t               res;
    int                 fail_count;
    int                 pending;
    logic [COUNT_W-1:0] fill_level;
    int                 idle_pct;
    bit                 growing;

    indexed_shift_stack #(.DEPTH(DEPTH)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    indexed_shift_stack_checker #(.DEPTH(DEPTH)) stack_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending),
        .fill_level (fill_level)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic req_t make_request(logic [ACTION_W-1:0] action,
                                          logic [POS_W-1:0] position,
                                          logic [WORD_W-1:0] value);
        req_t r;

        r.action   = action;
        r.position = position;
        r.value    = value;
        return r;
    endfunction

    // Mostly a small pool of words, so that removal by value finds matches.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd99;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h8000_0000;
            6:       return 32'h0000_5A5A;
            default: return $urandom();
        endcase
    endfunction

    // A random request, leaning towards growth or shrinkage of the store.
    function automatic req_t random_request(logic [COUNT_W-1:0] level, bit grow);
        req_t        r;
        int unsigned roll;
        int unsigned top_pos;

        roll    = $urandom_range(99);
        top_pos = (level > 127) ? 127 : level;
        if (grow)
            r.action = (roll < 35) ? ACT_PUSH   : (roll < 55) ? ACT_INSERT :
                       (roll < 67) ? ACT_READ   : (roll < 79) ? ACT_WRITE  :
                       (roll < 85) ? ACT_DELETE : (roll < 90) ? ACT_POP    :
                       (roll < 97) ? ACT_REMOVE : ACT_UNUSED;
        else
            r.action = (roll < 25) ? ACT_POP    : (roll < 45) ? ACT_DELETE :
                       (roll < 65) ? ACT_REMOVE : (roll < 75) ? ACT_READ   :
                       (roll < 85) ? ACT_WRITE  : (roll < 90) ? ACT_PUSH   :
                       (roll < 97) ? ACT_INSERT : ACT_UNUSED;
        if ($urandom_range(99) < 85)
            r.position = POS_W'($urandom_range(top_pos, 0));
        else
            r.position = POS_W'($urandom_range(127));
        r.value = pick_value();
        return r;
    endfunction

    // Present one request, with random gaps first, and hold it until taken.
    task automatic issue(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending until every result due has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        req      <= '0;
        idle_pct = 0;
        growing  = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every action but push, and the unused code, on the empty store.
        issue(make_request(ACT_POP,    7'd0,   32'd0));
        issue(make_request(ACT_DELETE, 7'd0,   32'd0));
        issue(make_request(ACT_READ,   7'd0,   32'd0));
        issue(make_request(ACT_REMOVE, 7'd0,   32'd5));
        issue(make_request(ACT_WRITE,  7'd0,   32'd7));
        issue(make_request(ACT_INSERT, 7'd1,   32'd7));
        issue(make_request(ACT_UNUSED, 7'd127, 32'hFFFF_FFFF));

        // Build a short list with the word extremes, then probe its edges.
        issue(make_request(ACT_PUSH,   7'd0,   32'h7FFF_FFFF));
        issue(make_request(ACT_PUSH,   7'd0,   32'h8000_0000));
        issue(make_request(ACT_INSERT, 7'd0,   32'hFFFF_FFFF));
        issue(make_request(ACT_INSERT, 7'd3,   32'd99));
        issue(make_request(ACT_READ,   7'd127, 32'd0));
        issue(make_request(ACT_READ,   7'd4,   32'd0));
        issue(make_request(ACT_READ,   7'd0,   32'd0));
        issue(make_request(ACT_WRITE,  7'd1,   32'd0));
        issue(make_request(ACT_WRITE,  7'd4,   32'd1));
        issue(make_request(ACT_INSERT, 7'd5,   32'd1));
        issue(make_request(ACT_DELETE, 7'd3,   32'd0));
        issue(make_request(ACT_DELETE, 7'd3,   32'd0));
        issue(make_request(ACT_DELETE, 7'd0,   32'd0));
        issue(make_request(ACT_REMOVE, 7'd0,   32'd12345));
        issue(make_request(ACT_REMOVE, 7'd0,   32'd0));
        issue(make_request(ACT_POP,    7'd0,   32'd0));
        issue(make_request(ACT_POP,    7'd0,   32'd0));
        drain();

        // Random phases: no gaps, heavy gaps, light gaps, no gaps again.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 79;
                2:       idle_pct = 10;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_REQUESTS / 4; n++)
            begin
                // Linger a little at full before draining back to empty.
                if (fill_level >= DEPTH && $urandom_range(9) == 0)
                    growing = 1'b0;
                else if (fill_level == 0)
                    growing = 1'b1;
                issue(random_request(fill_level, growing));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/iss_pkg.sv
src/iss_ctrl.sv
src/iss_datapath.sv
src/indexed_shift_stack.sv
dv/indexed_shift_stack_checker.sv
dv/indexed_shift_stack_test.sv
